/* rtl/core/rau_pkg.sv */
// Package for the rational arithmetic unit: operation codes, sequencer states
// and small helpers. No dependencies.
`default_nettype none
package rau_pkg;

    localparam int WIDE = 64;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_LT  = 4'd5,
        OP_LE  = 4'd6,
        OP_GT  = 4'd7,
        OP_NEG = 4'd8
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DISPATCH,
        ST_GSWAP,
        ST_GTEST,
        ST_DIV,
        ST_DPOST,
        ST_JOBEND,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        DK_REM,
        DK_QX,
        DK_QY
    } t_dkind;

    function automatic logic [WIDE-1:0] f_mag(input logic [WIDE-1:0] x);
        return x[WIDE-1] ? (WIDE'(0) - x) : x;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit top level: one shared multiplier and one shared
// bit-serial divider under a sequencer. Depends on rau_pkg.
`default_nettype none
// The block takes one item holding an operation code and two fractions
// a_num/a_den and b_num/b_den, and returns one item with a result fraction,
// a truth bit and an invalid flag. All arithmetic is done in 64-bit two's
// complement with wrap, and the result fields are the low 33 bits. Add and
// subtract reduce the cross-multiplied fraction by a signed Euclid gcd;
// multiply and divide do not reduce; equality compares both operands each
// reduced by its own gcd. The block works on one item at a time and drops
// s_axis_tready until the item has been handed to the output register, which
// lets the next item in while a result still waits. An item first forms three
// products on the shared multiplier; for add and subtract, and for equality
// and less-or-equal with both denominators nonzero, it then passes through
// the bit-serial divider once per Euclid remainder step and twice more for
// the final quotients of each reduction.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // operation[3:0], a_num, a_den, b_num, b_den (OPERAND_BITS each), zero fill
    input  wire logic [((4+4*OPERAND_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // res_num[32:0], res_den[65:33], truth[66], invalid[67], zero fill
    output logic [71:0]                m_axis_tdata
);

    localparam int OB = OPERAND_BITS;
    localparam int PW = 2 * OB;

    t_state r_state, n_state;

    logic [3:0]               r_op, n_op;
    logic signed [OB-1:0]     r_an, r_ad, r_bn, r_bd, n_an, n_ad, n_bn, n_bd;
    logic [1:0]               r_mcnt, n_mcnt;
    logic [WIDE-1:0]          r_p0, r_p1, r_p2, n_p0, n_p1, n_p2;
    logic [WIDE-1:0]          r_jx, r_jy, n_jx, n_jy;
    logic [WIDE-1:0]          r_gx, r_gy, r_g, n_gx, n_gy, n_g;
    logic [WIDE-1:0]          r_qx, r_qy, r_sx, r_sy, n_qx, n_qy, n_sx, n_sy;
    logic                     r_pass, n_pass, r_gzero, n_gzero;
    logic [WIDE-1:0]          r_dvd, r_dvs, r_rem, n_dvd, n_dvs, n_rem;
    logic                     r_dneg, r_qneg, n_dneg, n_qneg;
    logic [5:0]               r_dcnt, n_dcnt;
    t_dkind                   r_dkind, n_dkind;
    logic [71:0]              r_odata, n_odata;
    logic                     r_ovalid, n_ovalid;

    logic signed [OB-1:0]     mul_a, mul_b;
    logic signed [PW-1:0]     mul_p;
    logic [WIDE-1:0]          prod;
    logic [WIDE-1:0]          rem_sh;
    logic [WIDE-1:0]          q_signed, r_signed;
    logic [WIDE-1:0]          ext_an, ext_ad, ext_bn, ext_bd;
    logic                     in_acc, fin_load, ok, eq_op;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign fin_load = (r_state == ST_FIN) && (!r_ovalid || m_axis_tready);
    assign ok       = (r_ad != '0) && (r_bd != '0);
    assign eq_op    = (r_op == OP_EQ) || (r_op == OP_LE);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign ext_an = WIDE'(r_an);
    assign ext_ad = WIDE'(r_ad);
    assign ext_bn = WIDE'(r_bn);
    assign ext_bd = WIDE'(r_bd);

    // Shared multiplier: operand pair chosen by the step counter.
    always_comb begin
        unique case (r_mcnt)
            2'd0: begin
                mul_a = r_an;
                mul_b = (r_op == OP_MUL) ? r_bn : r_bd;
            end
            2'd1: begin
                if (r_op == OP_MUL) begin
                    mul_a = r_ad;
                    mul_b = r_bd;
                end else if (r_op == OP_DIV) begin
                    mul_a = r_ad;
                    mul_b = r_bn;
                end else begin
                    mul_a = r_bn;
                    mul_b = r_ad;
                end
            end
            default: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign prod  = WIDE'(mul_p);

    // Divider step and signed results of a finished division.
    assign rem_sh   = {r_rem[WIDE-2:0], r_dvd[WIDE-1]};
    assign q_signed = r_qneg ? (WIDE'(0) - r_dvd) : r_dvd;
    assign r_signed = r_dneg ? (WIDE'(0) - r_rem) : r_rem;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (in_acc) n_state = ST_MUL;
            ST_MUL:      if (r_mcnt == 2'd2) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                if (r_op == OP_ADD || r_op == OP_SUB || (eq_op && ok)) begin
                    n_state = ST_GSWAP;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_GSWAP:    n_state = ST_GTEST;
            ST_GTEST: begin
                if (r_gy == '0 && r_gx == '0) begin
                    n_state = ST_JOBEND;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV:      if (r_dcnt == 6'd63) n_state = ST_DPOST;
            ST_DPOST: begin
                unique case (r_dkind)
                    DK_REM:  n_state = ST_GTEST;
                    DK_QX:   n_state = ST_DIV;
                    default: n_state = ST_JOBEND;
                endcase
            end
            ST_JOBEND:   n_state = (eq_op && !r_pass) ? ST_GSWAP : ST_FIN;
            ST_FIN:      if (fin_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_op = r_op;   n_an = r_an;   n_ad = r_ad;   n_bn = r_bn;   n_bd = r_bd;
        n_mcnt = r_mcnt;
        n_p0 = r_p0;   n_p1 = r_p1;   n_p2 = r_p2;
        n_jx = r_jx;   n_jy = r_jy;   n_gx = r_gx;   n_gy = r_gy;   n_g = r_g;
        n_qx = r_qx;   n_qy = r_qy;   n_sx = r_sx;   n_sy = r_sy;
        n_pass = r_pass; n_gzero = r_gzero;
        n_dvd = r_dvd; n_dvs = r_dvs; n_rem = r_rem;
        n_dneg = r_dneg; n_qneg = r_qneg; n_dcnt = r_dcnt; n_dkind = r_dkind;
        n_odata = r_odata;
        n_ovalid = r_ovalid && !m_axis_tready;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op   = s_axis_tdata[3:0];
                    n_an   = s_axis_tdata[4 +: OB];
                    n_ad   = s_axis_tdata[4+OB +: OB];
                    n_bn   = s_axis_tdata[4+2*OB +: OB];
                    n_bd   = s_axis_tdata[4+3*OB +: OB];
                    n_mcnt = 2'd0;
                end
            end
            ST_MUL: begin
                unique case (r_mcnt)
                    2'd0:    n_p0 = prod;
                    2'd1:    n_p1 = prod;
                    default: n_p2 = prod;
                endcase
                n_mcnt = r_mcnt + 2'd1;
            end
            ST_DISPATCH: begin
                n_pass  = 1'b0;
                n_gzero = 1'b0;
                if (eq_op) begin
                    n_jx = ext_an;
                    n_jy = ext_ad;
                end else begin
                    n_jx = (r_op == OP_SUB) ? (r_p0 - r_p1) : (r_p0 + r_p1);
                    n_jy = r_p2;
                end
            end
            ST_GSWAP: begin
                // The gcd starts with the larger magnitude first.
                if (f_mag(r_jy) > f_mag(r_jx)) begin
                    n_gx = r_jy;
                    n_gy = r_jx;
                end else begin
                    n_gx = r_jx;
                    n_gy = r_jy;
                end
            end
            ST_GTEST: begin
                n_rem  = '0;
                n_dcnt = '0;
                if (r_gy == '0) begin
                    if (r_gx == '0) begin
                        n_gzero = 1'b1;
                    end else begin
                        n_g     = r_gx;
                        n_dvd   = f_mag(r_jx);
                        n_dvs   = f_mag(r_gx);
                        n_dneg  = r_jx[WIDE-1];
                        n_qneg  = r_jx[WIDE-1] ^ r_gx[WIDE-1];
                        n_dkind = DK_QX;
                    end
                end else begin
                    n_dvd   = f_mag(r_gx);
                    n_dvs   = f_mag(r_gy);
                    n_dneg  = r_gx[WIDE-1];
                    n_qneg  = r_gx[WIDE-1] ^ r_gy[WIDE-1];
                    n_dkind = DK_REM;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle.
                n_dcnt = r_dcnt + 6'd1;
                if (rem_sh >= r_dvs) begin
                    n_rem = rem_sh - r_dvs;
                    n_dvd = {r_dvd[WIDE-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh;
                    n_dvd = {r_dvd[WIDE-2:0], 1'b0};
                end
            end
            ST_DPOST: begin
                unique case (r_dkind)
                    DK_REM: begin
                        n_gx = r_gy;
                        n_gy = r_signed;
                    end
                    DK_QX: begin
                        n_qx    = q_signed;
                        n_rem   = '0;
                        n_dcnt  = '0;
                        n_dvd   = f_mag(r_jy);
                        n_dvs   = f_mag(r_g);
                        n_dneg  = r_jy[WIDE-1];
                        n_qneg  = r_jy[WIDE-1] ^ r_g[WIDE-1];
                        n_dkind = DK_QY;
                    end
                    default: n_qy = q_signed;
                endcase
            end
            ST_JOBEND: begin
                if (eq_op && !r_pass) begin
                    n_sx   = r_qx;
                    n_sy   = r_qy;
                    n_jx   = ext_bn;
                    n_jy   = ext_bd;
                    n_pass = 1'b1;
                end
            end
            ST_FIN: begin
                if (fin_load) begin
                    n_ovalid = 1'b1;
                    n_odata  = '0;
                    priority if (r_op == OP_ADD || r_op == OP_SUB) begin
                        if (r_gzero) begin
                            n_odata[67] = 1'b1;
                        end else begin
                            n_odata[32:0]  = r_qx[32:0];
                            n_odata[65:33] = r_qy[32:0];
                            n_odata[67]    = (r_qy == '0);
                        end
                    end else if (r_op == OP_MUL || r_op == OP_DIV) begin
                        n_odata[32:0]  = r_p0[32:0];
                        n_odata[65:33] = r_p1[32:0];
                        n_odata[67]    = (r_p1 == '0);
                    end else if (r_op == OP_EQ || r_op == OP_LT
                                 || r_op == OP_LE || r_op == OP_GT) begin
                        if (!ok) begin
                            n_odata[67] = 1'b1;
                        end else begin
                            unique case (r_op)
                                OP_EQ: n_odata[66] = (r_sx == r_qx) && (r_sy == r_qy);
                                OP_LT: n_odata[66] = $signed(r_p0) < $signed(r_p1);
                                OP_LE: n_odata[66] = ($signed(r_p0) < $signed(r_p1))
                                           || ((r_sx == r_qx) && (r_sy == r_qy));
                                default: n_odata[66] = $signed(r_p1) < $signed(r_p0);
                            endcase
                        end
                    end else if (r_op == OP_NEG) begin
                        n_odata[32:0]  = 33'(WIDE'(0) - ext_an);
                        n_odata[65:33] = ext_ad[32:0];
                        n_odata[67]    = (r_ad == '0);
                    end else begin
                        n_odata[67] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_op <= n_op;   r_an <= n_an;   r_ad <= n_ad;   r_bn <= n_bn;   r_bd <= n_bd;
        r_mcnt <= n_mcnt;
        r_p0 <= n_p0;   r_p1 <= n_p1;   r_p2 <= n_p2;
        r_jx <= n_jx;   r_jy <= n_jy;   r_gx <= n_gx;   r_gy <= n_gy;   r_g <= n_g;
        r_qx <= n_qx;   r_qy <= n_qy;   r_sx <= n_sx;   r_sy <= n_sy;
        r_pass <= n_pass; r_gzero <= n_gzero;
        r_dvd <= n_dvd; r_dvs <= n_dvs; r_rem <= n_rem;
        r_dneg <= n_dneg; r_qneg <= n_qneg; r_dcnt <= n_dcnt; r_dkind <= n_dkind;
        r_odata <= n_odata;
    end

endmodule
`default_nettype wire

/* tb/sv/rau_checker.sv */
// Checker for the rational arithmetic unit: watches both stream channels,
// predicts each result from the accepted input item and compares. Uses rau_pkg.
module rau_checker
    import rau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [71:0] m_axis_tdata,
    output int               o_fail_count,
    output int               o_pending
);

    // Packed from the top bit down, so num lands in the lowest bits.
    typedef struct packed {
        logic        invalid;
        logic        truth;
        logic [32:0] den;
        logic [32:0] num;
    } t_fraction_result;

    t_fraction_result expected_results[$];

    // Signed Euclid gcd: larger magnitude first, truncating remainder.
    function automatic longint signed_gcd(longint x, longint y);
        longint t;
        longint r;
        if (f_mag(y) > f_mag(x)) begin
            t = x;
            x = y;
            y = t;
        end
        while (y != 0) begin
            r = (y == 1 || y == -1) ? 64'sd0 : x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic longint trunc_div(longint x, longint y);
        if (y == -1) return -x;
        return x / y;
    endfunction

    function automatic t_fraction_result predict_fraction(logic [71:0] data);
        t_fraction_result res;
        logic [3:0] op;
        longint an, ad, bn, bd, p, q, n, d, g, g2, rn, rd;
        logic lt, gt, eq;
        op = data[3:0];
        an = longint'($signed(data[19:4]));
        ad = longint'($signed(data[35:20]));
        bn = longint'($signed(data[51:36]));
        bd = longint'($signed(data[67:52]));
        rn = 0;
        rd = 0;
        res = '0;
        case (op)
            OP_ADD, OP_SUB: begin
                p = an * bd;
                q = bn * ad;
                n = (op == OP_ADD) ? p + q : p - q;
                d = ad * bd;
                g = signed_gcd(n, d);
                if (g == 0) begin
                    res.invalid = 1'b1;
                end else begin
                    rn = trunc_div(n, g);
                    rd = trunc_div(d, g);
                    res.invalid = (rd == 0);
                end
            end
            OP_MUL, OP_DIV: begin
                rn = (op == OP_MUL) ? an * bn : an * bd;
                rd = (op == OP_MUL) ? ad * bd : ad * bn;
                res.invalid = (rd == 0);
            end
            OP_EQ, OP_LT, OP_LE, OP_GT: begin
                if (ad == 0 || bd == 0) begin
                    res.invalid = 1'b1;
                end else begin
                    lt = (an * bd) < (bn * ad);
                    gt = (bn * ad) < (an * bd);
                    g = signed_gcd(an, ad);
                    g2 = signed_gcd(bn, bd);
                    eq = trunc_div(an, g) == trunc_div(bn, g2)
                        && trunc_div(ad, g) == trunc_div(bd, g2);
                    case (op)
                        OP_EQ: res.truth = eq;
                        OP_LT: res.truth = lt;
                        OP_LE: res.truth = lt | eq;
                        default: res.truth = gt;
                    endcase
                end
            end
            OP_NEG: begin
                rn = -an;
                rd = ad;
                res.invalid = (ad == 0);
            end
            default: res.invalid = 1'b1;
        endcase
        res.num = rn[32:0];
        res.den = rd[32:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_fraction_result want;
        t_fraction_result got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_fraction(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[67:0];
                if (expected_results.size() == 0) begin
                    $error("unexpected result item %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.num != want.num)
                            $error("res_num expected %h got %h", want.num, got.num);
                        if (got.den != want.den)
                            $error("res_den expected %h got %h", want.den, got.den);
                        if (got.truth != want.truth)
                            $error("truth expected %b got %b", want.truth, got.truth);
                        if (got.invalid != want.invalid)
                            $error("invalid expected %b got %b", want.invalid, got.invalid);
                    end
                end
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top for rational_arithmetic_unit_core: clock, reset, item stimulus
// and verdict. Depends on rau_pkg and rau_checker.
module tb;
    import rau_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam longint CYCLE_LIMIT = 64'd20000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // operation[3:0], a_num[19:4], a_den[35:20], b_num[51:36], b_den[67:52], zero fill
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // res_num[32:0], res_den[65:33], truth[66], invalid[67], zero fill
    logic [71:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    longint      cycle_count;
    logic        hold_off;

    rational_arithmetic_unit_core #(.OPERAND_BITS(16)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rau_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Random gap length: mostly zero or short, now and then long.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Operand values lean toward the interesting edges of the 16-bit range.
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'(int'($urandom_range(0, 12)) - 6);
            4, 5: return 16'(int'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // Hand one item to the block; valid stays high until it is taken, and
    // stays high into the next item when there is no gap.
    task automatic send_item(input logic [3:0] op, input logic [15:0] an,
                             input logic [15:0] ad, input logic [15:0] bn,
                             input logic [15:0] bd);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {4'b0, bd, bn, ad, an, op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // The receiver side: random stalls, plus one long hold-off early on so
    // that the output register fills and the block stops taking input.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
                stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (cycle_count == 200);
        hold_off = 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Watchdog: cycle counter with a generous limit.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("rational_arithmetic_unit_core test failed");
                $finish;
            end
        end
    end

    initial begin
        logic [3:0] op;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed items: every operation, field extremes, zero gcd, zero
        // denominators in comparisons, unused codes, the most negative values.
        send_item(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
        send_item(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
        send_item(OP_ADD, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(OP_SUB, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        send_item(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_item(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(OP_MUL, 16'd3, 16'd0, 16'd5, 16'd7);
        send_item(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
        send_item(OP_DIV, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
        send_item(OP_EQ, 16'd2, 16'd4, 16'd1, 16'd2);
        send_item(OP_EQ, 16'hFFFE, 16'hFFFC, 16'd1, 16'd2);
        send_item(OP_EQ, 16'd1, 16'd0, 16'd1, 16'd0);
        send_item(OP_LT, 16'd1, 16'd3, 16'd1, 16'd2);
        send_item(OP_LT, 16'd1, 16'hFFFF, 16'd1, 16'd2);
        send_item(OP_LE, 16'd1, 16'd2, 16'd2, 16'd4);
        send_item(OP_LE, 16'd1, 16'd2, 16'd1, 16'd0);
        send_item(OP_GT, 16'd1, 16'd2, 16'd1, 16'd2);
        send_item(OP_GT, 16'h7FFF, 16'd1, 16'h8000, 16'd1);
        send_item(OP_NEG, 16'h8000, 16'd5, 16'd9, 16'd9);
        send_item(OP_NEG, 16'd4, 16'd0, 16'd0, 16'd0);
        send_item(4'd9, 16'd1, 16'd1, 16'd1, 16'd1);
        send_item(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Random items over all codes, unused codes now and then.
        repeat (RANDOM_ITEMS) begin
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
            send_item(op, pick_operand(), pick_operand(), pick_operand(),
                      pick_operand());
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d items: all nine operations, unused codes, zero and extreme",
                 RANDOM_ITEMS + 22);
        $display("operands, random stalls on both sides and one long output hold-off.");
        if (fail_count == 0) begin
            $display("rational_arithmetic_unit_core test passed");
        end else begin
            $display("rational_arithmetic_unit_core test failed");
        end
        $finish;
    end

endmodule
